FILE: hdl/vn_pkg.sv
package vn_pkg;

    localparam int SQRT_STEPS = 20;
    localparam int DIV_STEPS  = 16;
    localparam logic [15:0] ONE_Q14 = 16'd16384;

    typedef struct packed {
        logic [30:0]        sx;
        logic [30:0]        sy;
        logic [30:0]        sz;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vn_sqr_t;

    typedef struct packed {
        logic [39:0]        rad;
        logic [21:0]        rem;
        logic [19:0]        root;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vn_sq_t;

    typedef struct packed {
        logic [19:0]        len;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vn_rnd_t;

    typedef struct packed {
        logic [15:0] low;
        logic [20:0] part;
        logic [15:0] quo;
        logic        neg;
    } vn_lane_t;

    typedef struct packed {
        vn_lane_t [2:0] lane;
        logic [20:0]    dvs;
        logic [19:0]    len;
    } vn_dv_t;

    // one digit of the square root: two radicand bits in, one root bit out
    function automatic vn_sq_t vn_sqrt_step(vn_sq_t a);
        vn_sq_t      r;
        logic [23:0] cur;
        logic [23:0] trial;
        r     = a;
        cur   = {a.rem, a.rad[39:38]};
        trial = {2'b00, a.root, 2'b01};
        if (cur >= trial) begin
            r.rem  = 22'(cur - trial);
            r.root = {a.root[18:0], 1'b1};
        end else begin
            r.rem  = cur[21:0];
            r.root = {a.root[18:0], 1'b0};
        end
        r.rad = {a.rad[37:0], 2'b00};
        return r;
    endfunction

    // one quotient bit of the restoring division for each lane
    function automatic vn_dv_t vn_div_step(vn_dv_t a);
        vn_dv_t      r;
        logic [21:0] cur;
        r = a;
        for (int i = 0; i < 3; i++) begin
            cur = {a.lane[i].part, a.lane[i].low[15]};
            if (cur >= {1'b0, a.dvs}) begin
                r.lane[i].part = 21'(cur - {1'b0, a.dvs});
                r.lane[i].quo  = {a.lane[i].quo[14:0], 1'b1};
            end else begin
                r.lane[i].part = cur[20:0];
                r.lane[i].quo  = {a.lane[i].quo[14:0], 1'b0};
            end
            r.lane[i].low = {a.lane[i].low[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: hdl/vn_pipe_reg.sv
module vn_pipe_reg #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         valid_reg;
    logic [W-1:0] data_reg;

    // load when empty or when the word below moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

endmodule

FILE: hdl/vn_sqrt.sv
module vn_sqrt (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  vn_pkg::vn_sq_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output vn_pkg::vn_sq_t out_data
);
    import vn_pkg::*;

    vn_sq_t d [0:SQRT_STEPS];
    vn_sq_t n [0:SQRT_STEPS-1];
    logic   v [0:SQRT_STEPS];
    logic   r [0:SQRT_STEPS];

    assign d[0]     = in_data;
    assign v[0]     = in_valid;
    assign in_ready = r[0];
    assign r[SQRT_STEPS] = out_ready;
    assign out_valid = v[SQRT_STEPS];
    assign out_data  = d[SQRT_STEPS];

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
        assign n[i] = vn_sqrt_step(d[i]);
        vn_pipe_reg #(.W($bits(vn_sq_t))) u_reg (
            .aclk(aclk), .aresetn(aresetn),
            .in_valid(v[i]), .in_ready(r[i]), .in_data(n[i]),
            .out_valid(v[i+1]), .out_ready(r[i+1]), .out_data(d[i+1])
        );
    end

endmodule

FILE: hdl/vn_div.sv
module vn_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  vn_pkg::vn_dv_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output vn_pkg::vn_dv_t out_data
);
    import vn_pkg::*;

    vn_dv_t d [0:DIV_STEPS];
    vn_dv_t n [0:DIV_STEPS-1];
    logic   v [0:DIV_STEPS];
    logic   r [0:DIV_STEPS];

    assign d[0]     = in_data;
    assign v[0]     = in_valid;
    assign in_ready = r[0];
    assign r[DIV_STEPS] = out_ready;
    assign out_valid = v[DIV_STEPS];
    assign out_data  = d[DIV_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        assign n[i] = vn_div_step(d[i]);
        vn_pipe_reg #(.W($bits(vn_dv_t))) u_reg (
            .aclk(aclk), .aresetn(aresetn),
            .in_valid(v[i]), .in_ready(r[i]), .in_data(n[i]),
            .out_valid(v[i+1]), .out_ready(r[i+1]), .out_data(d[i+1])
        );
    end

endmodule

FILE: hdl/vector_normalize.sv
// vector_normalize: length and unit direction of a 3D integer vector.
//
// Input channel (s_valid/s_ready): one word carries s_in_x, s_in_y, s_in_z,
// signed 16-bit components; give s_in_z = 0 for a 2D vector.
// Result channel (m_valid/m_ready): one word per input word, in order, with
// m_vec_length (unsigned Q16.4), m_unit_x/y/z (signed Q1.14, saturated to
// +-1.0) and m_valid_res. When the length is at or below the threshold,
// m_valid_res is 0, the unit components are 0 and the length still shows.
// Configuration: cfg_wr_en/cfg_wr_data write the 20-bit zero threshold
// (Q16.4); write it only while no word is in flight.
// Throughput: one word per cycle while the receiver keeps m_ready high. The
// pipeline has 41 register stages: the 20-stage square root (one root bit
// per stage), the 16-stage divider (one quotient bit per stage) and five
// stages for squaring, summing, rounding, divider setup and output
// formatting.
// Reset (aresetn low, synchronous): the pipeline empties and the threshold
// returns to 1. When the receiver stalls, words close up into empty stages
// and s_ready drops only once the whole pipeline is full.
module vector_normalize (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [19:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_in_x,
    input  logic signed [15:0] s_in_y,
    input  logic signed [15:0] s_in_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_unit_x,
    output logic signed [15:0] m_unit_y,
    output logic signed [15:0] m_unit_z,
    output logic [19:0]        m_vec_length,
    output logic               m_valid_res
);
    import vn_pkg::*;

    typedef struct packed {
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
        logic [19:0]        len;
        logic               ok;
    } vn_out_t;

    logic [19:0] thr_reg;

    // hold the threshold between writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 20'd1;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // stage: squares of the components
    vn_sqr_t     sqr_next, sqr_q;
    logic        sqr_v, sqr_r;
    logic signed [31:0] px, py, pz;

    always_comb begin
        px = s_in_x * s_in_x;
        py = s_in_y * s_in_y;
        pz = s_in_z * s_in_z;
        sqr_next.sx = px[30:0];
        sqr_next.sy = py[30:0];
        sqr_next.sz = pz[30:0];
        sqr_next.x  = s_in_x;
        sqr_next.y  = s_in_y;
        sqr_next.z  = s_in_z;
    end

    vn_pipe_reg #(.W($bits(vn_sqr_t))) u_sqr (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_data(sqr_next),
        .out_valid(sqr_v), .out_ready(sqr_r), .out_data(sqr_q)
    );

    // stage: sum of squares, scaled by 256 so the root comes out in Q16.4
    vn_sq_t      sum_next, sum_q, root_q;
    logic        sum_v, sum_r, root_v, root_r;
    logic [31:0] sum_s;

    always_comb begin
        sum_s = 32'(sqr_q.sx) + 32'(sqr_q.sy) + 32'(sqr_q.sz);
        sum_next.rad  = {sum_s, 8'h00};
        sum_next.rem  = '0;
        sum_next.root = '0;
        sum_next.x    = sqr_q.x;
        sum_next.y    = sqr_q.y;
        sum_next.z    = sqr_q.z;
    end

    vn_pipe_reg #(.W($bits(vn_sq_t))) u_sum (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(sqr_v), .in_ready(sqr_r), .in_data(sum_next),
        .out_valid(sum_v), .out_ready(sum_r), .out_data(sum_q)
    );

    vn_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(sum_v), .in_ready(sum_r), .in_data(sum_q),
        .out_valid(root_v), .out_ready(root_r), .out_data(root_q)
    );

    // stage: round the root to nearest (remainder above root rounds up)
    vn_rnd_t rnd_next, rnd_q;
    logic    rnd_v, rnd_r;

    always_comb begin
        rnd_next.len = (root_q.rem > {2'b00, root_q.root}) ? 20'(root_q.root + 20'd1)
                                                          : root_q.root;
        rnd_next.x   = root_q.x;
        rnd_next.y   = root_q.y;
        rnd_next.z   = root_q.z;
    end

    vn_pipe_reg #(.W($bits(vn_rnd_t))) u_rnd (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(root_v), .in_ready(root_r), .in_data(rnd_next),
        .out_valid(rnd_v), .out_ready(rnd_r), .out_data(rnd_q)
    );

    // stage: divider setup, dividend 2*mag*2^18 + L over divisor 2*L
    vn_dv_t       prep_next, prep_q, quo_q;
    logic         prep_v, prep_r, quo_v, quo_r;
    logic signed [15:0] comp [0:2];
    logic [15:0]  mag;
    logic [34:0]  num;

    always_comb begin
        comp[0] = rnd_q.x;
        comp[1] = rnd_q.y;
        comp[2] = rnd_q.z;
        prep_next.len = rnd_q.len;
        prep_next.dvs = {rnd_q.len, 1'b0};
        mag = '0;
        num = '0;
        for (int i = 0; i < 3; i++) begin
            mag = comp[i][15] ? 16'(-comp[i]) : comp[i];
            num = {mag, 19'd0} + 35'(rnd_q.len);
            prep_next.lane[i].neg  = comp[i][15];
            prep_next.lane[i].part = {2'b00, num[34:16]};
            prep_next.lane[i].low  = num[15:0];
            prep_next.lane[i].quo  = '0;
        end
    end

    vn_pipe_reg #(.W($bits(vn_dv_t))) u_prep (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(rnd_v), .in_ready(rnd_r), .in_data(prep_next),
        .out_valid(prep_v), .out_ready(prep_r), .out_data(prep_q)
    );

    vn_div u_div (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(prep_v), .in_ready(prep_r), .in_data(prep_q),
        .out_valid(quo_v), .out_ready(quo_r), .out_data(quo_q)
    );

    // output stage: saturate, apply sign, drop the unit vector when too short
    vn_out_t     out_next, out_q;
    logic [15:0] sat [0:2];
    logic [15:0] sgn [0:2];
    logic        ok;

    always_comb begin
        ok = quo_q.len > thr_reg;
        for (int i = 0; i < 3; i++) begin
            sat[i] = (quo_q.lane[i].quo > ONE_Q14) ? ONE_Q14 : quo_q.lane[i].quo;
            sgn[i] = quo_q.lane[i].neg ? 16'(-sat[i]) : sat[i];
            if (!ok) begin
                sgn[i] = '0;
            end
        end
        out_next.ux  = sgn[0];
        out_next.uy  = sgn[1];
        out_next.uz  = sgn[2];
        out_next.len = quo_q.len;
        out_next.ok  = ok;
    end

    vn_pipe_reg #(.W($bits(vn_out_t))) u_out (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(quo_v), .in_ready(quo_r), .in_data(out_next),
        .out_valid(m_valid), .out_ready(m_ready), .out_data(out_q)
    );

    assign m_unit_x     = out_q.ux;
    assign m_unit_y     = out_q.uy;
    assign m_unit_z     = out_q.uz;
    assign m_vec_length = out_q.len;
    assign m_valid_res  = out_q.ok;

endmodule
